@@ sv/pump_run_time_monitor_defines.svh @@
// Assertion macros shared by the pump run-time monitor RTL.
// Included by name from modules that carry assertions; no other dependencies.
`ifndef PUMP_RUN_TIME_MONITOR_DEFINES_SVH
`define PUMP_RUN_TIME_MONITOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define PRTM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prtm assertion failed");
// next-cycle implication
`define PRTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prtm assertion failed");
`else
`define PRTM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PRTM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/prtm_pkg.sv @@
// Types and constants for the pump run-time monitor.
// No dependencies; used by every module of the block.
`default_nettype none
package prtm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int HOLDOFF_W   = 10;
   localparam int REPORT_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_ON_MS          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_IDLE_MS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_LIMIT        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_INTERVAL_MS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_MS         = 3'd4;

   localparam logic [15:0]          RST_MIN_ON_MS          = 16'd10000;
   localparam logic [31:0]          RST_MAX_IDLE_MS        = 32'd86400000;
   localparam logic [7:0]           RST_ALARM_LIMIT        = 8'd2;
   localparam logic [REPORT_W-1:0]  RST_REPORT_INTERVAL_MS = 16'd2000;
   localparam logic [HOLDOFF_W-1:0] RST_HOLDOFF_MS         = 10'd300;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_LOW_AIR     = 2'd1,
      STATUS_NO_ACTIVITY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TOG_NONE = 2'd0,
      TOG_ON   = 2'd1,
      TOG_OFF  = 2'd2
   } toggle_type;

   typedef struct packed {
      logic [15:0]          min_on_ms;
      logic [31:0]          max_idle_ms;
      logic [7:0]           alarm_limit;
      logic [REPORT_W-1:0]  report_interval_ms;
      logic [HOLDOFF_W-1:0] holdoff_ms;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic       pump_led;
      toggle_type toggle_event;
      logic       report_now;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/prtm_csr.sv @@
// Configuration registers of the pump run-time monitor.
// Depends on prtm_pkg for the register indexes, reset values and cfg_type.
`default_nettype none
module prtm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [prtm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [prtm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output prtm_pkg::cfg_type                     cfg
);

   prtm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            prtm_pkg::CSR_MIN_ON_MS:          cfg_in.min_on_ms = csr_wdata[15:0];
            prtm_pkg::CSR_MAX_IDLE_MS:        cfg_in.max_idle_ms = csr_wdata[31:0];
            prtm_pkg::CSR_ALARM_LIMIT:        cfg_in.alarm_limit = csr_wdata[7:0];
            prtm_pkg::CSR_REPORT_INTERVAL_MS: begin
               cfg_in.report_interval_ms = csr_wdata[prtm_pkg::REPORT_W-1:0];
            end
            prtm_pkg::CSR_HOLDOFF_MS:         begin
               cfg_in.holdoff_ms = csr_wdata[prtm_pkg::HOLDOFF_W-1:0];
            end
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_on_ms          <= prtm_pkg::RST_MIN_ON_MS;
         cfg_ff.max_idle_ms        <= prtm_pkg::RST_MAX_IDLE_MS;
         cfg_ff.alarm_limit        <= prtm_pkg::RST_ALARM_LIMIT;
         cfg_ff.report_interval_ms <= prtm_pkg::RST_REPORT_INTERVAL_MS;
         cfg_ff.holdoff_ms         <= prtm_pkg::RST_HOLDOFF_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ sv/prtm_core.sv @@
// Run-time monitor state and per-tick update logic.
// Depends on prtm_pkg and the assertion macros in pump_run_time_monitor_defines.svh.
`default_nettype none
`include "pump_run_time_monitor_defines.svh"
module prtm_core #(
   parameter int TIMER_BITS = 32,
   parameter int COUNT_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              pump_switch,
   input  wire prtm_pkg::cfg_type cfg,
   output prtm_pkg::rsp_type      result
);

   localparam int IDLE_W = (TIMER_BITS > 32) ? TIMER_BITS : 32;
   localparam int LIM_W  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   logic                            level_ff, level_in;
   logic [TIMER_BITS-1:0]           since_ff, since_in, since_inc;
   logic [prtm_pkg::REPORT_W-1:0]   rep_ff, rep_in, rep_inc;
   logic [prtm_pkg::HOLDOFF_W-1:0]  holdoff_ff, holdoff_in;
   logic [COUNT_BITS-1:0]           short_ff, short_in, short_sat;
   logic [COUNT_BITS-1:0]           good_ff, good_in, good_sat;
   prtm_pkg::status_type            status_ff, status_in;
   logic                            armed_ff, armed_in;
   prtm_pkg::toggle_type            toggle;
   logic                            report;

   always_comb begin
      since_inc  = (&since_ff) ? since_ff : since_ff + 1'b1;
      rep_inc    = (&rep_ff) ? rep_ff : rep_ff + 1'b1;
      short_sat  = (&short_ff) ? short_ff : short_ff + 1'b1;
      good_sat   = (&good_ff) ? good_ff : good_ff + 1'b1;
      level_in   = level_ff;
      since_in   = since_inc;
      rep_in     = rep_inc;
      holdoff_in = holdoff_ff;
      short_in   = short_ff;
      good_in    = good_ff;
      status_in  = status_ff;
      armed_in   = armed_ff;
      toggle     = prtm_pkg::TOG_NONE;
      report     = 1'b0;

      if (holdoff_ff != '0) begin
         holdoff_in = holdoff_ff - 1'b1;
      end else if (pump_switch != level_ff) begin
         level_in   = pump_switch;
         holdoff_in = cfg.holdoff_ms;
         if (pump_switch) begin
            toggle   = prtm_pkg::TOG_ON;
            since_in = '0;
         end else begin
            toggle = prtm_pkg::TOG_OFF;
            // off edge: judge the run just ended
            if (since_inc < TIMER_BITS'(cfg.min_on_ms)) begin
               short_in = short_sat;
               if (LIM_W'(short_sat) > LIM_W'(cfg.alarm_limit)) begin
                  status_in = prtm_pkg::STATUS_LOW_AIR;
                  good_in   = '0;
               end
            end else begin
               good_in = good_sat;
               if (good_sat > short_ff) begin
                  status_in = prtm_pkg::STATUS_OK;
                  short_in  = '0;
               end
            end
         end
      end

      // flag no-activity once per excursion above the idle limit
      if (IDLE_W'(since_in) > IDLE_W'(cfg.max_idle_ms)) begin
         if (armed_ff) begin
            armed_in  = 1'b0;
            status_in = prtm_pkg::STATUS_NO_ACTIVITY;
         end
      end else begin
         armed_in = 1'b1;
      end

      if (rep_inc >= cfg.report_interval_ms) begin
         report = 1'b1;
         rep_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         since_ff   <= '0;
         rep_ff     <= '0;
         holdoff_ff <= '0;
         short_ff   <= '0;
         good_ff    <= '0;
         status_ff  <= prtm_pkg::STATUS_NO_ACTIVITY;
         armed_ff   <= 1'b1;
      end else if (accept) begin
         level_ff   <= level_in;
         since_ff   <= since_in;
         rep_ff     <= rep_in;
         holdoff_ff <= holdoff_in;
         short_ff   <= short_in;
         good_ff    <= good_in;
         status_ff  <= status_in;
         armed_ff   <= armed_in;
      end
   end

   assign result.status       = status_in;
   assign result.pump_led     = level_in;
   assign result.toggle_event = toggle;
   assign result.report_now   = report;

   `PRTM_ASSERT_IMPL(a_holdoff_quiet, clock, reset, accept && holdoff_ff != '0, toggle == prtm_pkg::TOG_NONE)
   `PRTM_ASSERT_NEXT(a_on_clears_timer, clock, reset, accept && toggle == prtm_pkg::TOG_ON, since_ff == '0)
   `PRTM_ASSERT_NEXT(a_edge_loads_holdoff, clock, reset, accept && toggle != prtm_pkg::TOG_NONE, holdoff_ff == $past(cfg.holdoff_ms))
   `PRTM_ASSERT_NEXT(a_report_clears, clock, reset, accept && report, rep_ff == '0)

endmodule
`default_nettype wire

@@ sv/prtm_out.sv @@
// Result register of the pump run-time monitor: holds one beat for the receiver.
// Depends on prtm_pkg for rsp_type.
`default_nettype none
module prtm_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_valid,
   output logic                   load_ready,
   input  wire prtm_pkg::rsp_type load_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output prtm_pkg::rsp_type      rsp_data
);

   logic              valid_ff, valid_in;
   prtm_pkg::rsp_type data_ff;

   // refill in the same cycle the held beat leaves
   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

@@ sv/pump_run_time_monitor.sv @@
// Pump run-time monitor: usage notes
// One req_ beat is one millisecond sample of the pump switch (req_pump_switch,
// 1 = running). Every accepted beat gives exactly one rsp_ beat: status
// (0 ok, 1 low air, 2 no activity), pump_led (accepted level), toggle_event
// (0 none, 1 on, 2 off) and report_now (periodic one-beat report request).
// The result of a beat is registered at the edge that accepts it and held in a
// single output register. Throughput is one beat per cycle while the receiver
// takes results; it is set by the state update, which is one pass of logic
// from the state registers to the result register.
// req_ready is high while the output register is empty or being emptied, so
// a stalled receiver stops intake after one beat and nothing is lost.
// The csr_ port writes one register per cycle with csr_wr_en high: index 0
// min_on_ms, 1 max_idle_ms, 2 alarm_limit, 3 report_interval_ms, 4 holdoff_ms;
// other indexes are ignored. Write only while the block is idle.
// Synchronous reset restores the register defaults, clears the timers and
// counts, sets status to no activity and empties the output register.
// Depends on prtm_pkg, prtm_csr, prtm_core and prtm_out.
`default_nettype none
module pump_run_time_monitor #(
   parameter int TIMER_BITS = 32,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_pump_switch,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_pump_led,
   output logic [1:0]                            rsp_toggle_event,
   output logic                                  rsp_report_now,
   input  wire logic                             csr_wr_en,
   input  wire logic [prtm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [prtm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   prtm_pkg::cfg_type cfg;
   prtm_pkg::rsp_type core_result;
   prtm_pkg::rsp_type out_data;
   logic              accept;

   assign accept = req_valid && req_ready;

   prtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prtm_core #(
      .TIMER_BITS (TIMER_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pump_switch (req_pump_switch),
      .cfg         (cfg),
      .result      (core_result)
   );

   prtm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid),
      .load_ready (req_ready),
      .load_data  (core_result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (out_data)
   );

   assign rsp_status       = out_data.status;
   assign rsp_pump_led     = out_data.pump_led;
   assign rsp_toggle_event = out_data.toggle_event;
   assign rsp_report_now   = out_data.report_now;

endmodule
`default_nettype wire

@@ dv/pump_run_time_monitor_test.sv @@
// Self-checking bench for pump_run_time_monitor: predicts every result beat from
// the accepted switch samples and the register settings, and compares field by field.
// Depends on prtm_pkg and the pump_run_time_monitor RTL.

class run_time_tracker;
   prtm_pkg::cfg_type                    cfg;
   logic                                 level;
   logic [31:0]                          since_on;
   logic [prtm_pkg::REPORT_W-1:0]        report_age;
   logic [prtm_pkg::HOLDOFF_W-1:0]       holdoff_left;
   logic [7:0]                           short_runs;
   logic [7:0]                           good_runs;
   prtm_pkg::status_type                 status;
   logic                                 idle_armed;
   prtm_pkg::rsp_type                    due_beats[$];
   int                                   errors;
   int                                   checked;
   int                                   on_edges;
   int                                   off_edges;
   int                                   reports;
   int                                   low_air_entries;

   function new();
      cfg = '{min_on_ms: prtm_pkg::RST_MIN_ON_MS, max_idle_ms: prtm_pkg::RST_MAX_IDLE_MS,
              alarm_limit: prtm_pkg::RST_ALARM_LIMIT,
              report_interval_ms: prtm_pkg::RST_REPORT_INTERVAL_MS,
              holdoff_ms: prtm_pkg::RST_HOLDOFF_MS};
      level        = 1'b0;
      since_on     = '0;
      report_age   = '0;
      holdoff_left = '0;
      short_runs   = '0;
      good_runs    = '0;
      status       = prtm_pkg::STATUS_NO_ACTIVITY;
      idle_armed   = 1'b1;
   endfunction

   function void set_reg(logic [prtm_pkg::CSR_INDEX_W-1:0] idx,
                         logic [prtm_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         prtm_pkg::CSR_MIN_ON_MS:          cfg.min_on_ms   = data[15:0];
         prtm_pkg::CSR_MAX_IDLE_MS:        cfg.max_idle_ms = data;
         prtm_pkg::CSR_ALARM_LIMIT:        cfg.alarm_limit = data[7:0];
         prtm_pkg::CSR_REPORT_INTERVAL_MS: begin
            cfg.report_interval_ms = data[prtm_pkg::REPORT_W-1:0];
         end
         prtm_pkg::CSR_HOLDOFF_MS:         cfg.holdoff_ms  = data[prtm_pkg::HOLDOFF_W-1:0];
         default: ;
      endcase
   endfunction

   function void grade_run(logic [31:0] run_ms);
      if (run_ms < cfg.min_on_ms) begin
         if (short_runs != '1) short_runs += 1;
         if (short_runs > cfg.alarm_limit) begin
            if (status != prtm_pkg::STATUS_LOW_AIR) low_air_entries++;
            status    = prtm_pkg::STATUS_LOW_AIR;
            good_runs = '0;
         end
      end else begin
         if (good_runs != '1) good_runs += 1;
         if (good_runs > short_runs) begin
            status     = prtm_pkg::STATUS_OK;
            short_runs = '0;
         end
      end
   endfunction

   // one accepted sample -> one expected result beat
   function void note_sample(logic sw);
      prtm_pkg::rsp_type want;
      want.toggle_event = prtm_pkg::TOG_NONE;
      want.report_now   = 1'b0;
      if (since_on != '1) since_on += 1;
      if (report_age != '1) report_age += 1;
      if (holdoff_left != '0) begin
         holdoff_left -= 1;
      end else if (sw != level) begin
         level        = sw;
         holdoff_left = cfg.holdoff_ms;
         if (sw) begin
            want.toggle_event = prtm_pkg::TOG_ON;
            since_on          = '0;
            on_edges++;
         end else begin
            want.toggle_event = prtm_pkg::TOG_OFF;
            grade_run(since_on);
            off_edges++;
         end
      end
      // no-activity fires once per excursion above the limit
      if (since_on > cfg.max_idle_ms) begin
         if (idle_armed) begin
            idle_armed = 1'b0;
            status     = prtm_pkg::STATUS_NO_ACTIVITY;
         end
      end else begin
         idle_armed = 1'b1;
      end
      if (report_age >= cfg.report_interval_ms) begin
         want.report_now = 1'b1;
         report_age      = '0;
         reports++;
      end
      want.status   = status;
      want.pump_led = level;
      due_beats.push_back(want);
   endfunction

   function void flag(string field, logic [1:0] want, logic [1:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
   endfunction

   function void check_beat(logic [1:0] st, logic led, logic [1:0] tog, logic rep);
      prtm_pkg::rsp_type want;
      if (due_beats.size() == 0) begin
         $display("%0t: result beat with nothing expected, got status %0d led %0d toggle %0d",
                  $time, st, led, tog);
         errors++;
         return;
      end
      want = due_beats.pop_front();
      checked++;
      if (st !== want.status) flag("status", want.status, st);
      if (led !== want.pump_led) flag("pump_led", {1'b0, want.pump_led}, {1'b0, led});
      if (tog !== want.toggle_event) flag("toggle_event", want.toggle_event, tog);
      if (rep !== want.report_now) flag("report_now", {1'b0, want.report_now}, {1'b0, rep});
   endfunction

   function int pending();
      return due_beats.size();
   endfunction
endclass

module pump_run_time_monitor_test;

   localparam int INDEX_W   = prtm_pkg::CSR_INDEX_W;
   localparam int DATA_W    = prtm_pkg::CSR_DATA_W;
   localparam int REPORT_W  = prtm_pkg::REPORT_W;
   localparam int HOLDOFF_W = prtm_pkg::HOLDOFF_W;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic               req_pump_switch = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [1:0]         rsp_status;
   logic               rsp_pump_led;
   logic [1:0]         rsp_toggle_event;
   logic               rsp_report_now;
   logic               csr_wr_en       = 1'b0;
   logic [INDEX_W-1:0] csr_index       = '0;
   logic [DATA_W-1:0]  csr_wdata       = '0;

   bit calm         = 1'b0;   // no idling on either side
   bit hold_request = 1'b0;   // asks the receiver for one long stall
   int settings     = 0;

   run_time_tracker board = new();

   pump_run_time_monitor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pump_switch  (req_pump_switch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_pump_led     (rsp_pump_led),
      .rsp_toggle_event (rsp_toggle_event),
      .rsp_report_now   (rsp_report_now),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timeout with %0d beats outstanding", board.pending());
      $display("[pump_run_time_monitor] ERROR");
      $finish;
   end

   // values read here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_beat(rsp_status, rsp_pump_led, rsp_toggle_event, rsp_report_now);
         if (req_valid && req_ready)
            board.note_sample(req_pump_switch);
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = 199;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 30);
         end
      end
   end

   task automatic offer_sample(input logic sw);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pump_switch <= sw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // bits sent MSB first
   task automatic offer_bits(input logic [31:0] bits, input int count);
      int i;
      for (i = count - 1; i >= 0; i--) offer_sample(bits[i]);
      req_valid <= 1'b0;
   endtask

   // alternating switch levels of random length, sized to the current settings,
   // with single-tick glitches mixed in
   task automatic switch_stretch(input int n_ticks);
      int   left;
      int   len;
      int   span;
      int   idle_span;
      int   roll;
      logic lvl;
      span = int'(board.cfg.min_on_ms) + int'(board.cfg.holdoff_ms) + 4;
      if (span > 80) span = 80;
      idle_span = 40;
      if (board.cfg.max_idle_ms < 120)
         idle_span = int'(board.cfg.max_idle_ms) + int'(board.cfg.holdoff_ms) + 8;
      if (idle_span > 150) idle_span = 150;
      lvl  = $urandom_range(1);
      left = n_ticks;
      while (left > 0) begin
         roll = $urandom_range(99);
         if (roll < 15) len = 1;
         else if (roll < 30) len = $urandom_range(1, idle_span);
         else len = $urandom_range(1, span);
         if (len > left) len = left;
         repeat (len) offer_sample(lvl);
         left -= len;
         lvl = ~lvl;
      end
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.set_reg(idx, data);
      @(posedge clock);
   endtask

   // unused upper bits carry junk; one write goes to an unmapped index
   task automatic load_settings(input prtm_pkg::cfg_type c);
      logic [INDEX_W-1:0] stray;
      stray = prtm_pkg::CSR_HOLDOFF_MS + INDEX_W'($urandom_range(1, 3));
      write_reg(prtm_pkg::CSR_MIN_ON_MS, {16'($urandom()), c.min_on_ms});
      write_reg(prtm_pkg::CSR_MAX_IDLE_MS, c.max_idle_ms);
      write_reg(stray, $urandom());
      write_reg(prtm_pkg::CSR_ALARM_LIMIT, {24'($urandom()), c.alarm_limit});
      write_reg(prtm_pkg::CSR_REPORT_INTERVAL_MS, {16'($urandom()), c.report_interval_ms});
      write_reg(prtm_pkg::CSR_HOLDOFF_MS, {22'($urandom()), c.holdoff_ms});
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   function automatic prtm_pkg::cfg_type random_settings();
      prtm_pkg::cfg_type c;
      case ($urandom_range(9))
         0:       c.min_on_ms = '0;
         1:       c.min_on_ms = 16'($urandom());
         default: c.min_on_ms = 16'($urandom_range(1, 30));
      endcase
      case ($urandom_range(9))
         0:       c.max_idle_ms = '0;
         1:       c.max_idle_ms = '1;
         2:       c.max_idle_ms = $urandom();
         default: c.max_idle_ms = $urandom_range(5, 120);
      endcase
      case ($urandom_range(9))
         0:       c.alarm_limit = '0;
         1:       c.alarm_limit = 8'($urandom());
         default: c.alarm_limit = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(9))
         0:       c.report_interval_ms = '0;
         1:       c.report_interval_ms = REPORT_W'($urandom());
         default: c.report_interval_ms = REPORT_W'($urandom_range(1, 25));
      endcase
      case ($urandom_range(9))
         0:       c.holdoff_ms = '0;
         1:       c.holdoff_ms = HOLDOFF_W'($urandom_range(9, 60));
         default: c.holdoff_ms = HOLDOFF_W'($urandom_range(1, 8));
      endcase
      return c;
   endfunction

   task automatic wait_drained();
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      prtm_pkg::cfg_type c;
      int                n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: idle switch, status stays no-activity
      offer_bits(32'b0, 5);
      wait_drained();

      // zero hold-off, report every tick: short run to low air, long runs back to ok,
      // quiet stretch to no activity, then re-arm
      c = '{min_on_ms: 16'd3, max_idle_ms: 32'd4, alarm_limit: 8'd0,
            report_interval_ms: '0, holdoff_ms: '0};
      load_settings(c);
      offer_bits(32'b10111101110000001, 17);
      wait_drained();

      for (n = 0; n < 8; n++) begin
         c = random_settings();
         if (n == 1) begin
            c.min_on_ms   = '0;
            c.max_idle_ms = '0;
         end
         load_settings(c);
         if (n == 2) hold_request = 1'b1;
         calm = (n == 4);
         switch_stretch(25);
         wait_drained();
      end
      calm = 1'b0;

      // every run short with an unreachable limit: short count climbs, status untouched
      c = '{min_on_ms: '1, max_idle_ms: 32'd2, alarm_limit: '1,
            report_interval_ms: REPORT_W'(9), holdoff_ms: '0};
      load_settings(c);
      repeat (60) begin
         offer_sample(1'b1);
         repeat ($urandom_range(1, 2)) offer_sample(1'b0);
      end
      req_valid <= 1'b0;
      wait_drained();

      // top of every register; long hold-off swallows the glitch
      c = '{min_on_ms: '1, max_idle_ms: '1, alarm_limit: '1,
            report_interval_ms: '1, holdoff_ms: '1};
      load_settings(c);
      offer_bits(32'b010, 3);
      switch_stretch(30);
      wait_drained();
      repeat (4) @(posedge clock);

      $display("pump monitor: %0d result beats checked across %0d register settings",
               board.checked, settings);
      $display("  %0d on edges, %0d off edges, %0d report pulses, %0d low-air entries",
               board.on_edges, board.off_edges, board.reports, board.low_air_entries);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("[pump_run_time_monitor] OK");
      end else begin
         $display("[pump_run_time_monitor] ERROR");
      end
      $finish;
   end

endmodule
